>>> sv/alids_pkg.sv
// Shared types and codes for the array list block.
package alids_pkg;

    // Operation codes
    localparam logic [2:0] OP_CLEAR  = 3'd0;
    localparam logic [2:0] OP_INSERT = 3'd1;
    localparam logic [2:0] OP_DELETE = 3'd2;
    localparam logic [2:0] OP_SEARCH = 3'd3;
    localparam logic [2:0] OP_READ   = 3'd4;

    // Status codes
    localparam logic [2:0] ST_OK     = 3'd0;
    localparam logic [2:0] ST_FULL   = 3'd1;
    localparam logic [2:0] ST_EMPTY  = 3'd2;
    localparam logic [2:0] ST_BADPOS = 3'd3;
    localparam logic [2:0] ST_MISS   = 3'd4;

    // Field widths of the stream words
    localparam int POS_W  = 5;
    localparam int VAL_W  = 32;
    localparam int ST_W   = 3;
    localparam int OCNT_W = 6;

    // Broadcast from the control to every cell of the chain
    typedef struct packed {
        logic             cap;     // word accepted: capture compare result
        logic             ins;     // insert: shift up above pos, load value at pos
        logic             del;     // delete: shift down from pos
        logic [POS_W-1:0] pos;     // position of the accepted word
        logic [VAL_W-1:0] value;   // value of the accepted word
        logic [POS_W-1:0] rd_pos;  // position held for the read phase
    } t_cell_cmd;

endpackage

>>> sv/alids_cell.sv
// One list slot: holds an entry, shifts with its neighbors, compares and selects.
module alids_cell #(
    parameter int DATA_WIDTH = 32,
    parameter int CNT_W      = 6,
    parameter int IDX        = 0
) (
    input  logic                  i_clk,
    input  alids_pkg::t_cell_cmd  i_cmd,
    input  logic [CNT_W-1:0]      i_count,     // entry count before the word
    input  logic [DATA_WIDTH-1:0] i_left,      // entry of slot IDX-1
    input  logic [DATA_WIDTH-1:0] i_right,     // entry of slot IDX+1
    output logic [DATA_WIDTH-1:0] o_data,
    output logic                  o_match,     // registered compare hit, slot in list
    output logic [DATA_WIDTH-1:0] o_rd_data    // entry when selected by rd_pos, else 0
);

    localparam int PW = (CNT_W > alids_pkg::POS_W) ? CNT_W : alids_pkg::POS_W;
    localparam logic [PW-1:0] IDX_P = PW'(IDX);

    logic [DATA_WIDTH-1:0] r_data;
    logic [DATA_WIDTH-1:0] n_data;
    logic                  r_match;
    logic [PW-1:0]         pos_p;
    logic [DATA_WIDTH-1:0] val_dw;

    assign pos_p  = PW'(i_cmd.pos);
    assign val_dw = DATA_WIDTH'(i_cmd.value);

    always_comb begin
        n_data = r_data;
        if (i_cmd.ins) begin
            if (IDX_P > pos_p) begin
                n_data = i_left;
            end else if (IDX_P == pos_p) begin
                n_data = val_dw;
            end
        end else if (i_cmd.del) begin
            if (IDX_P >= pos_p) begin
                n_data = i_right;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
        if (i_cmd.cap) begin
            r_match <= (r_data == val_dw) && (IDX_P < PW'(i_count));
        end
    end

    assign o_data    = r_data;
    assign o_match   = r_match;
    assign o_rd_data = (IDX_P == PW'(i_cmd.rd_pos)) ? r_data : '0;

endmodule

>>> sv/alids_find.sv
// Priority encoder over the cell hits and OR-merge of the selected read entry.
module alids_find #(
    parameter int DEPTH      = 32,
    parameter int DATA_WIDTH = 32
) (
    input  logic [DEPTH-1:0]                 i_match,
    input  logic [DEPTH-1:0][DATA_WIDTH-1:0] i_rd_data,
    output logic                             o_hit,
    output logic [$clog2(DEPTH)-1:0]         o_index,
    output logic [DATA_WIDTH-1:0]            o_rd_data
);

    localparam int IW = $clog2(DEPTH);

    always_comb begin
        o_hit     = |i_match;
        o_index   = '0;
        o_rd_data = '0;
        // lowest set bit wins
        for (int i = DEPTH - 1; i >= 0; i--) begin
            if (i_match[i]) begin
                o_index = IW'(i);
            end
        end
        for (int i = 0; i < DEPTH; i++) begin
            o_rd_data = o_rd_data | i_rd_data[i];
        end
    end

endmodule

>>> sv/array_list_insert_delete_search.sv
// Top level of the array list: command control, cell chain and result register.
// An accepted word enters the evaluate state, where its result loads into the output register;
//   a stalled master side holds the word in the evaluate cycle until the register frees.
// A new word is taken only in the idle state; the search/read reduction over the cell row
//   runs in the evaluate state, during which s_axis_tready is low.
// A new word is taken while a finished result still waits on the master side.
// Reset (i_rst_n low, synchronous) empties the list, drops any pending result, holds tready low.
module array_list_insert_delete_search #(
    parameter int DEPTH      = 32,
    parameter int DATA_WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [2:0] operation, [7:3] position, [39:8] value
    input  logic [39:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [2:0] status, [7:3] found_index, [39:8] read_data, [45:40] entry_count, [47:46] zero
    output logic [47:0] m_axis_tdata
);

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int IW    = $clog2(DEPTH);
    localparam int PW    = (CNT_W > alids_pkg::POS_W) ? CNT_W : alids_pkg::POS_W;
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);

    // control states
    localparam logic S_IDLE = 1'b0;
    localparam logic S_EVAL = 1'b1;

    // input word fields
    logic [2:0]                  in_op;
    logic [alids_pkg::POS_W-1:0] in_pos;
    logic [alids_pkg::VAL_W-1:0] in_val;

    assign in_op  = s_axis_tdata[2:0];
    assign in_pos = s_axis_tdata[7:3];
    assign in_val = s_axis_tdata[39:8];

    logic                         r_state;
    logic [2:0]                   r_op;
    logic [alids_pkg::POS_W-1:0]  r_pos;
    logic [alids_pkg::ST_W-1:0]   r_status;
    logic [CNT_W-1:0]             r_count;
    logic [CNT_W-1:0]             n_count;
    logic                         r_out_valid;
    logic [alids_pkg::ST_W-1:0]   r_out_status;
    logic [alids_pkg::POS_W-1:0]  r_out_found;
    logic [alids_pkg::VAL_W-1:0]  r_out_rdata;
    logic [alids_pkg::OCNT_W-1:0] r_out_count;

    logic                        accept;
    logic [alids_pkg::ST_W-1:0]  acc_status;
    logic [PW-1:0]               pos_p;
    logic [PW-1:0]               cnt_p;
    alids_pkg::t_cell_cmd        cmd;

    // no word is taken while reset is held
    assign s_axis_tready = (r_state == S_IDLE) && i_rst_n;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign pos_p         = PW'(in_pos);
    assign cnt_p         = PW'(r_count);

    // status of the word as known at accept; search settles its own in the next cycle
    always_comb begin
        acc_status = alids_pkg::ST_OK;
        n_count    = r_count;
        case (in_op)
            alids_pkg::OP_CLEAR: begin
                n_count = '0;
            end
            alids_pkg::OP_INSERT: begin
                if (r_count >= DEPTH_C) begin
                    acc_status = alids_pkg::ST_FULL;
                end else if (pos_p > cnt_p) begin
                    acc_status = alids_pkg::ST_BADPOS;
                end else begin
                    n_count = r_count + CNT_W'(1);
                end
            end
            alids_pkg::OP_DELETE, alids_pkg::OP_READ: begin
                if (r_count == '0) begin
                    acc_status = alids_pkg::ST_EMPTY;
                end else if (pos_p >= cnt_p) begin
                    acc_status = alids_pkg::ST_BADPOS;
                end else if (in_op == alids_pkg::OP_DELETE) begin
                    n_count = r_count - CNT_W'(1);
                end
            end
            default: begin
                // search and unused codes leave the list alone
            end
        endcase
    end

    always_comb begin
        cmd.cap    = accept;
        cmd.ins    = accept && (in_op == alids_pkg::OP_INSERT)
                     && (acc_status == alids_pkg::ST_OK);
        cmd.del    = accept && (in_op == alids_pkg::OP_DELETE)
                     && (acc_status == alids_pkg::ST_OK);
        cmd.pos    = in_pos;
        cmd.value  = in_val;
        cmd.rd_pos = r_pos;
    end

    // cell chain: each slot sees its left and right neighbor
    logic [DEPTH-1:0][DATA_WIDTH-1:0] cell_data;
    logic [DEPTH-1:0][DATA_WIDTH-1:0] cell_rd;
    logic [DEPTH-1:0]                 cell_match;

    for (genvar k = 0; k < DEPTH; k++) begin : g_cell
        logic [DATA_WIDTH-1:0] left_d;
        logic [DATA_WIDTH-1:0] right_d;
        if (k == 0) begin : g_first
            assign left_d = '0;
        end else begin : g_left
            assign left_d = cell_data[k-1];
        end
        if (k == DEPTH - 1) begin : g_last
            assign right_d = '0;
        end else begin : g_right
            assign right_d = cell_data[k+1];
        end
        alids_cell #(
            .DATA_WIDTH (DATA_WIDTH),
            .CNT_W      (CNT_W),
            .IDX        (k)
        ) u_cell (
            .i_clk     (i_clk),
            .i_cmd     (cmd),
            .i_count   (r_count),
            .i_left    (left_d),
            .i_right   (right_d),
            .o_data    (cell_data[k]),
            .o_match   (cell_match[k]),
            .o_rd_data (cell_rd[k])
        );
    end

    logic                  f_hit;
    logic [IW-1:0]         f_index;
    logic [DATA_WIDTH-1:0] f_rdata;

    alids_find #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_find (
        .i_match   (cell_match),
        .i_rd_data (cell_rd),
        .o_hit     (f_hit),
        .o_index   (f_index),
        .o_rd_data (f_rdata)
    );

    // result assembly in the evaluate cycle
    logic                         load_out;
    logic                         is_search;
    logic [alids_pkg::ST_W-1:0]   ev_status;
    logic [alids_pkg::POS_W-1:0]  ev_found;
    logic [alids_pkg::VAL_W-1:0]  ev_rdata;

    assign load_out  = (r_state == S_EVAL) && (!r_out_valid || m_axis_tready);
    assign is_search = (r_op == alids_pkg::OP_SEARCH);

    always_comb begin
        ev_status = r_status;
        ev_found  = '0;
        ev_rdata  = '0;
        if (is_search) begin
            ev_status = f_hit ? alids_pkg::ST_OK : alids_pkg::ST_MISS;
            if (f_hit) begin
                ev_found = alids_pkg::POS_W'(f_index);
            end
        end
        if ((r_op == alids_pkg::OP_READ) && (r_status == alids_pkg::ST_OK)) begin
            ev_rdata = alids_pkg::VAL_W'(f_rdata);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_state <= S_EVAL;
                r_count <= n_count;
            end else if (load_out) begin
                r_state <= S_IDLE;
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op     <= in_op;
            r_pos    <= in_pos;
            r_status <= acc_status;
        end
        if (load_out) begin
            r_out_status <= ev_status;
            r_out_found  <= ev_found;
            r_out_rdata  <= ev_rdata;
            r_out_count  <= alids_pkg::OCNT_W'(r_count);
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {2'b00, r_out_count, r_out_rdata, r_out_found, r_out_status};

    // the list never holds more than DEPTH entries
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= DEPTH_C)
        else $error("entry count above depth");

    // an accepted word always goes through the evaluate cycle
    a_accept_eval: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == S_EVAL))
        else $error("accepted word skipped evaluation");

    // a successful insert grows the list by one
    a_insert_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (in_op == alids_pkg::OP_INSERT) && (acc_status == alids_pkg::ST_OK))
        |=> (r_count == $past(r_count) + CNT_W'(1)))
        else $error("insert did not grow the list");

    // a search hit lies inside the list
    a_hit_in_list: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_EVAL) && is_search && f_hit) |-> (CNT_W'(f_index) < r_count))
        else $error("search hit beyond entry count");

endmodule
